// ===== design/mk_pkg.sv =====
`default_nettype none
package mk_pkg;

	localparam int TIMER_WIDTH_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int DOT_W = 12;
	localparam int DASH_W = 12;
	localparam int LGAP_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [DOT_W-1:0]  DOT_RESET  = 12'd250;
	localparam logic [DASH_W-1:0] DASH_RESET = 12'd750;
	localparam logic [LGAP_W-1:0] LGAP_RESET = 16'(5 * 750);

	localparam logic [7:0] LETTER_BASE = 8'd65;
	localparam logic [7:0] DIGIT_BASE  = 8'd48;
	localparam logic [5:0] NUM_LETTERS = 6'd26;
	localparam int NUM_CODES = 36;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOT  = 2'd0,
		CFG_DASH = 2'd1,
		CFG_LGAP = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	// entry = length << 5 | pattern (bit i set: element i is a dash)
	localparam logic [7:0] CODE_TABLE [NUM_CODES] = '{
		8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80,
		8'h40, 8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86,
		8'h8B, 8'h62, 8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89,
		8'h8D, 8'h83,
		8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3,
		8'hA7, 8'hAF
	};

	typedef struct packed {
		logic       operation;
		logic [7:0] character;
	} req_t;

	typedef struct packed {
		logic key_level;
		logic tone_level;
		logic busy_res;
		logic rejected;
		logic letter_done;
	} rsp_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_load;
		logic       char_ok;
		logic [4:0] pat_bits;
		logic [2:0] pat_len;
	} cmd_t;

	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

// ===== design/mk_front.sv =====
`default_nettype none
module mk_front import mk_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	input  wire logic q_full,
	output logic      q_push,
	output cmd_t      q_cmd
);

	logic [7:0] let_off;
	logic [7:0] dig_off;
	logic       is_letter;
	logic       is_digit;
	logic [5:0] code_idx;
	logic [7:0] entry;

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		let_off   = req.character - LETTER_BASE;
		dig_off   = req.character - DIGIT_BASE;
		is_letter = req.character >= LETTER_BASE && let_off < 8'(NUM_LETTERS);
		is_digit  = req.character >= DIGIT_BASE && dig_off < 8'd10;
		code_idx  = '0;
		if (is_letter) begin
			code_idx = let_off[5:0];
		end else if (is_digit) begin
			code_idx = dig_off[5:0] + NUM_LETTERS;
		end
		entry = CODE_TABLE[code_idx];

		q_cmd          = '0;
		q_cmd.is_load  = req.operation == OP_LOAD;
		q_cmd.char_ok  = is_letter || is_digit;
		q_cmd.pat_bits = entry[4:0];
		q_cmd.pat_len  = entry[7:5];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_cmd.char_ok || q_cmd.pat_len != 3'd0))
		else $error("valid character mapped to empty pattern");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req.operation == OP_LOAD && req.character == 8'd32) |->
			!q_cmd.char_ok)
		else $error("space classified as valid character");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !req_stall)
		else $error("push while input stalled");

endmodule
`default_nettype wire

// ===== design/mk_queue.sv =====
`default_nettype none
module mk_queue import mk_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      q_valid,
	output cmd_t      q_cmd,
	input  wire logic pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== design/mk_back.sv =====
`default_nettype none
module mk_back import mk_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_wr_t cfg,
	input  wire logic    q_valid,
	input  wire cmd_t    q_cmd,
	output logic         q_pop,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output rsp_t         rsp
);

	localparam int LW = (TIMER_WIDTH > LGAP_W) ? TIMER_WIDTH : LGAP_W;
	localparam logic [TIMER_WIDTH-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_MARK = 2'd1,
		PH_GAP  = 2'd2,
		PH_LGAP = 2'd3
	} phase_t;

	logic [DOT_W-1:0]  dot_q;
	logic [DASH_W-1:0] dash_q;
	logic [LGAP_W-1:0] lgap_q;

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] tick_q, tick_d, tick_inc;
	logic [4:0]             bits_q, bits_d;
	logic [2:0]             len_q, len_d;
	logic [2:0]             elem_q, elem_d;
	logic                   tone_q, tone_d;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q, res;

	logic              is_dash;
	logic [DOT_W-1:0]  elem_len;
	logic [LW-1:0]     limit;
	logic              cnt_done;
	logic              more_elems;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign q_pop     = q_valid && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		tick_inc   = (tick_q == CNT_MAX) ? tick_q : tick_q + TIMER_WIDTH'(1);
		is_dash    = (elem_q < 3'd5) ? bits_q[elem_q] : 1'b0;
		elem_len   = is_dash ? dash_q : dot_q;
		case (phase_q)
			PH_MARK: limit = LW'({elem_len, 1'b0});
			PH_GAP:  limit = LW'(dot_q);
			default: limit = LW'(lgap_q);
		endcase
		cnt_done   = LW'(tick_inc) >= limit || tick_inc == CNT_MAX;
		more_elems = ({1'b0, elem_q} + 4'd1 < {1'b0, len_q}) && elem_q < 3'd4;

		phase_d = phase_q;
		tick_d  = tick_q;
		bits_d  = bits_q;
		len_d   = len_q;
		elem_d  = elem_q;
		tone_d  = tone_q;
		res     = '0;

		if (q_cmd.is_load) begin
			if (phase_q != PH_IDLE || !q_cmd.char_ok) begin
				res.rejected = 1'b1;
			end else begin
				bits_d  = q_cmd.pat_bits;
				len_d   = q_cmd.pat_len;
				elem_d  = '0;
				tick_d  = '0;
				tone_d  = 1'b0;
				phase_d = PH_MARK;
			end
		end else begin
			case (phase_q)
				PH_MARK: begin
					res.key_level  = 1'b1;
					res.tone_level = ~tone_q;
					tone_d         = ~tone_q;
					tick_d         = cnt_done ? '0 : tick_inc;
					if (cnt_done) begin
						phase_d = PH_GAP;
					end
				end
				PH_GAP: begin
					tick_d = cnt_done ? '0 : tick_inc;
					if (cnt_done) begin
						if (more_elems) begin
							elem_d  = elem_q + 3'd1;
							tone_d  = 1'b0;
							phase_d = PH_MARK;
						end else if (lgap_q == '0) begin
							res.letter_done = 1'b1;
							phase_d         = PH_IDLE;
						end else begin
							phase_d = PH_LGAP;
						end
					end
				end
				PH_LGAP: begin
					tick_d = cnt_done ? '0 : tick_inc;
					if (cnt_done) begin
						res.letter_done = 1'b1;
						phase_d         = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
		res.busy_res = phase_d != PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= DOT_RESET;
			dash_q      <= DASH_RESET;
			lgap_q      <= LGAP_RESET;
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bits_q      <= '0;
			len_q       <= '0;
			elem_q      <= '0;
			tone_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg.wr) begin
				case (cfg.index)
					CFG_DOT:  dot_q  <= cfg.data[DOT_W-1:0];
					CFG_DASH: dash_q <= cfg.data[DASH_W-1:0];
					CFG_LGAP: lgap_q <= cfg.data[LGAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (q_pop) begin
				phase_q     <= phase_d;
				tick_q      <= tick_d;
				bits_q      <= bits_d;
				len_q       <= len_d;
				elem_q      <= elem_d;
				tone_q      <= tone_d;
				rsp_q       <= res;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		elem_q <= 3'd4)
		else $error("element index past five elements");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_cmd.is_load && q_cmd.char_ok && phase_q == PH_IDLE) |=>
			(phase_q == PH_MARK && tick_q == '0 && rsp_q.busy_res))
		else $error("accepted load did not start a mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.letter_done) |-> !rsp_q.busy_res && !rsp_q.key_level)
		else $error("letter done while still busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.rejected) |-> !rsp_q.key_level && !rsp_q.letter_done)
		else $error("rejected load with keying activity");

endmodule
`default_nettype wire

// ===== design/morse_keyer.sv =====
// A result passes through the queue and then the output register after its item is accepted.
// Throughput: one item per cycle; the back end retires one queued item per cycle unless stalled.
// A two-entry queue separates input classification from the keying state machine.
// Reset (arst_n low, asynchronous): keyer idle, counters and queue cleared,
// registers back to dot 250, dash 750, letter gap 3750.
`default_nettype none
module morse_keyer import mk_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic    q_full;
	logic    q_push;
	cmd_t    push_cmd;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    q_pop;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	mk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	mk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (q_pop)
	);

	mk_back #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
